[rtl/sarr_pkg.sv]
// Shared types, codes and constants of the sorted address range resolver.
package sarr_pkg;

   // Default number of table entries
   localparam int TABLE_DEPTH = 1024;

   // Field widths
   localparam int ADDR_W   = 64;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 10;
   localparam int OFFSET_W = 32;
   localparam int WINDOW_W = 32;
   localparam int CSR_IDX_W = 2;

   // Result transaction packing, padded to whole bytes
   localparam int RSP_BITS   = STATUS_W + INDEX_W + OFFSET_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Register reset values
   localparam logic [ADDR_W-1:0]   BASE_RESET   = '0;
   localparam logic [ADDR_W-1:0]   LIMIT_RESET  = '1;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd65536;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULE_BASE  = 2'd0,
      CSR_MODULE_LIMIT = 2'd1,
      CSR_WINDOW_SIZE  = 2'd2
   } csr_index_type;

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_RESOLVED       = 3'd0,
      ST_NO_MATCH       = 3'd1,
      ST_OUTSIDE        = 3'd2,
      ST_UNAVAILABLE    = 3'd3,
      ST_NOT_CONFIGURED = 3'd4,
      ST_ACCEPTED       = 3'd5,
      ST_UNSORTED       = 3'd6,
      ST_FULL           = 3'd7
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH,
      S_FINAL,
      S_RESP
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic step;
      logic finish;
      logic deliver;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic search_go;
      logic step_more;
      logic out_free;
   } sts_type;

endpackage

[rtl/sorted_address_range_resolver.sv]
// Top level of the sorted address range resolver: controller, datapath and table RAM.
//
// Request channel (req_): one transaction per item. req_tuser carries the kind
// (append entry, lookup address, clear table), req_tdata the 64-bit address.
// Result channel (rsp_): exactly one transaction per request, in order, with
// status, entry index and offset packed into rsp_tdata.
// Configuration port (csr_): module base, module limit and window size, written
// by index; no read-back. The user writes them only while the block is idle; the block does not enforce this.
// Items are handled one at a time. Append, clear and early-out lookups pass
// through the execute and response states after acceptance; the next request is
// taken once the result has been loaded out. A searching lookup adds one RAM read
// and compare per halving of the range, up to ceil(log2(n+1)) reads for n entries,
// as the single RAM read port serves one read at a time.
// The result sits in an output register, so the next request is accepted as
// soon as a result has been loaded there; while the receiver stalls with a
// result still waiting, the following item is processed and then held.
// Reset (synchronous) empties the table, forgets any load and restores the
// register defaults, with no clearing pass.
module sorted_address_range_resolver #(
   parameter int TABLE_DEPTH = sarr_pkg::TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sarr_pkg::ADDR_W-1:0]     req_tdata,   // address
   input  logic [sarr_pkg::KIND_W-1:0]     req_tuser,   // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sarr_pkg::RSP_DATA_W-1:0] rsp_tdata,   // status, entry_index, offset, zero pad
   input  logic                            csr_we,
   input  logic [sarr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sarr_pkg::ADDR_W-1:0]     csr_wdata
);

   sarr_pkg::cmd_type cmd;
   sarr_pkg::sts_type sts;

   sarr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sarr_dp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

[rtl/sarr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sarr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sarr_ctrl.sv]
// Controller state machine that sequences append, clear, lookup search and result delivery.
module sarr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sarr_pkg::sts_type sts,
   output sarr_pkg::cmd_type cmd
);

   sarr_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sarr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sarr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = sarr_pkg::S_EXEC;
            end
         end
         sarr_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.search_go ? sarr_pkg::S_SEARCH : sarr_pkg::S_RESP;
         end
         sarr_pkg::S_SEARCH: begin
            cmd.step = 1'b1;
            state_in = sts.step_more ? sarr_pkg::S_SEARCH : sarr_pkg::S_FINAL;
         end
         sarr_pkg::S_FINAL: begin
            cmd.finish = 1'b1;
            state_in   = sarr_pkg::S_RESP;
         end
         sarr_pkg::S_RESP: begin
            if (sts.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = sarr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sarr_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[rtl/sarr_dp.sv]
// Datapath: registers, table bookkeeping, binary search step and result register.
module sarr_dp #(
   parameter int TABLE_DEPTH = sarr_pkg::TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sarr_pkg::ADDR_W-1:0]         req_tdata,
   input  logic [sarr_pkg::KIND_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sarr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [sarr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sarr_pkg::ADDR_W-1:0]         csr_wdata,
   input  sarr_pkg::cmd_type                   cmd,
   output sarr_pkg::sts_type                   sts
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (AW > sarr_pkg::INDEX_W) ? AW : sarr_pkg::INDEX_W;
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

   // Configuration registers
   logic [sarr_pkg::ADDR_W-1:0]   base_ff, limit_ff;
   logic [sarr_pkg::WINDOW_W-1:0] window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= sarr_pkg::BASE_RESET;
         limit_ff  <= sarr_pkg::LIMIT_RESET;
         window_ff <= sarr_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         case (sarr_pkg::csr_index_type'(csr_index))
            sarr_pkg::CSR_MODULE_BASE:  base_ff   <= csr_wdata;
            sarr_pkg::CSR_MODULE_LIMIT: limit_ff  <= csr_wdata;
            sarr_pkg::CSR_WINDOW_SIZE:  window_ff <= csr_wdata[sarr_pkg::WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   // Item, table state and search registers
   sarr_pkg::kind_type          kind_ff;
   logic [sarr_pkg::ADDR_W-1:0] addr_ff;
   logic [sarr_pkg::ADDR_W-1:0] rel_ff, rel_in;
   logic [sarr_pkg::ADDR_W-1:0] last_ff, last_in;
   logic [sarr_pkg::ADDR_W-1:0] cand_ff, cand_in;
   logic [AW-1:0]               cand_idx_ff, cand_idx_in;
   logic                        found_ff, found_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        attempted_ff, attempted_in;
   logic                        failed_ff, failed_in;
   logic [CW-1:0]               lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   sarr_pkg::status_type        res_status_ff, res_status_in;
   logic [sarr_pkg::INDEX_W-1:0]  res_index_ff, res_index_in;
   logic [sarr_pkg::OFFSET_W-1:0] res_offset_ff, res_offset_in;
   sarr_pkg::status_type          rsp_status_ff;
   logic [sarr_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [sarr_pkg::OFFSET_W-1:0] rsp_offset_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   // RAM port signals
   logic                        ram_we, ram_re;
   logic [AW-1:0]               ram_raddr;
   logic [sarr_pkg::ADDR_W-1:0] ram_rdata;

   // Combinational helpers
   logic                        outside, go_left, step_more;
   logic [CW-1:0]               lo_n, hi_n, mid_n, mid0;
   logic [sarr_pkg::ADDR_W-1:0] distance;
   logic [XW-1:0]               idx_ext;

   sarr_ram #(
      .WIDTH(sarr_pkg::ADDR_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(addr_ff),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Range check, first midpoint, distance and search step: narrow [lo, hi) around the entry just read
   always_comb begin
      outside   = (addr_ff < base_ff) || (addr_ff >= limit_ff);
      mid0      = count_ff >> 1;
      go_left   = rel_ff < ram_rdata;
      lo_n      = go_left ? lo_ff : mid_ff + CW'(1);
      hi_n      = go_left ? mid_ff : hi_ff;
      mid_n     = lo_n + ((hi_n - lo_n) >> 1);
      step_more = lo_n < hi_n;
      distance  = rel_ff - cand_ff;
      idx_ext   = XW'(cand_idx_ff);
   end

   assign sts.search_go = (kind_ff == sarr_pkg::KIND_LOOKUP) && !outside && attempted_ff &&
                          !failed_ff && (count_ff != '0);
   assign sts.step_more = step_more;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   // Next-state logic of the datapath
   always_comb begin
      rel_in        = rel_ff;
      last_in       = last_ff;
      cand_in       = cand_ff;
      cand_idx_in   = cand_idx_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      attempted_in  = attempted_ff;
      failed_in     = failed_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_offset_in = res_offset_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = mid0[AW-1:0];

      if (cmd.exec) begin
         res_status_in = sarr_pkg::ST_UNAVAILABLE;
         res_index_in  = '0;
         res_offset_in = '0;
         case (kind_ff)
            sarr_pkg::KIND_APPEND: begin
               attempted_in = 1'b1;
               if (failed_ff) begin
                  res_status_in = sarr_pkg::ST_UNAVAILABLE;
               end else if (count_ff == DepthC) begin
                  failed_in     = 1'b1;
                  res_status_in = sarr_pkg::ST_FULL;
               end else if ((count_ff != '0) && (addr_ff < last_ff)) begin
                  failed_in     = 1'b1;
                  res_status_in = sarr_pkg::ST_UNSORTED;
               end else begin
                  ram_we        = 1'b1;
                  count_in      = count_ff + CW'(1);
                  last_in       = addr_ff;
                  res_status_in = sarr_pkg::ST_ACCEPTED;
               end
            end
            sarr_pkg::KIND_LOOKUP: begin
               if (outside) begin
                  res_status_in = sarr_pkg::ST_OUTSIDE;
               end else if (!attempted_ff) begin
                  res_status_in = sarr_pkg::ST_NOT_CONFIGURED;
               end else if (failed_ff || (count_ff == '0)) begin
                  res_status_in = sarr_pkg::ST_UNAVAILABLE;
               end else begin
                  // Start the search over the whole table
                  rel_in    = addr_ff - base_ff;
                  lo_in     = '0;
                  hi_in     = count_ff;
                  mid_in    = mid0;
                  found_in  = 1'b0;
                  ram_re    = 1'b1;
                  ram_raddr = mid0[AW-1:0];
               end
            end
            sarr_pkg::KIND_CLEAR: begin
               count_in      = '0;
               attempted_in  = 1'b0;
               failed_in     = 1'b0;
               res_status_in = sarr_pkg::ST_ACCEPTED;
            end
            default: begin
               res_status_in = sarr_pkg::ST_UNAVAILABLE;
            end
         endcase
      end

      if (cmd.step) begin
         lo_in  = lo_n;
         hi_in  = hi_n;
         mid_in = mid_n;
         // Entry at or below the address: remember it as the best so far
         if (!go_left) begin
            cand_in     = ram_rdata;
            cand_idx_in = mid_ff[AW-1:0];
            found_in    = 1'b1;
         end
         ram_raddr = mid_n[AW-1:0];
         ram_re    = step_more;
      end

      if (cmd.finish) begin
         if (!found_ff || (distance >= sarr_pkg::ADDR_W'(window_ff))) begin
            res_status_in = sarr_pkg::ST_NO_MATCH;
            res_index_in  = '0;
            res_offset_in = '0;
         end else begin
            res_status_in = sarr_pkg::ST_RESOLVED;
            res_index_in  = idx_ext[sarr_pkg::INDEX_W-1:0];
            res_offset_in = distance[sarr_pkg::OFFSET_W-1:0];
         end
      end
   end

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         attempted_ff <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         attempted_ff <= attempted_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= sarr_pkg::kind_type'(req_tuser);
         addr_ff <= req_tdata;
      end
      rel_ff        <= rel_in;
      last_ff       <= last_in;
      cand_ff       <= cand_in;
      cand_idx_ff   <= cand_idx_in;
      found_ff      <= found_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_offset_ff <= res_offset_in;
      if (cmd.deliver) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_offset_ff <= res_offset_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sarr_pkg::RSP_DATA_W'({rsp_offset_ff, rsp_index_ff, rsp_status_ff});

endmodule
